// File: rtl/crcs_pkg.sv
// Package with shared types, constants and opcodes for the step core.
`timescale 1ns / 1ps
`default_nettype none
package crcs_pkg;
   localparam int MemWords = 16384;
   localparam int MemAw    = $clog2(MemWords);
   localparam logic [31:0] DataBase  = 32'h1000_0000;
   localparam logic [31:0] DataShift = 32'(MemWords * 2);
   localparam logic [31:0] MemBytes  = 32'(MemWords * 4);

   localparam logic [1:0] MODE_LOAD   = 2'd0;
   localparam logic [1:0] MODE_START  = 2'd1;
   localparam logic [1:0] MODE_EXEC   = 2'd2;
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   localparam logic [2:0] ERR_NONE = 3'd0;
   localparam logic [2:0] ERR_DIV0 = 3'd1;
   localparam logic [2:0] ERR_ADDR = 3'd2;
   localparam logic [2:0] ERR_OP   = 3'd3;
   localparam logic [2:0] ERR_PC   = 3'd4;

   localparam logic [5:0] OP_ADD = 6'd0, OP_SUB = 6'd1, OP_MUL = 6'd2, OP_DIV = 6'd3,
      OP_NOT = 6'd4, OP_AND = 6'd5, OP_NAND = 6'd6, OP_OR = 6'd7, OP_XOR = 6'd8,
      OP_XNOR = 6'd9, OP_MOV = 6'd10, OP_SGT = 6'd11, OP_SLT = 6'd12, OP_MAD = 6'd13,
      OP_ADDI = 6'd14, OP_SUBI = 6'd15, OP_MULI = 6'd16, OP_DIVI = 6'd17,
      OP_ANDI = 6'd18, OP_NANDI = 6'd19, OP_ORI = 6'd20, OP_XORI = 6'd21,
      OP_LW = 6'd22, OP_SW = 6'd23, OP_LB = 6'd24, OP_SB = 6'd25, OP_BEQ = 6'd26,
      OP_BNE = 6'd27, OP_CLR = 6'd28, OP_JMP = 6'd29, OP_JAL = 6'd30, OP_HALT = 6'd31;

   typedef struct packed {
      logic [1:0]  mode;
      logic [13:0] word_index;
      logic [31:0] load_data;
      logic [4:0]  reg_select;
   } req_type;

   typedef struct packed {
      logic [31:0] pc_value;
      logic        running;
      logic [2:0]  error_code;
      logic [31:0] reg_value;
      logic [31:0] executed_word;
   } rsp_type;

   typedef struct packed {
      logic        start;
      logic        is_div;
      logic [31:0] a;
      logic [31:0] b;
   } mdu_cmd_type;
endpackage
`default_nettype wire

// File: rtl/crcs_mdu.sv
// Shared multiply and divide unit, one bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module crcs_mdu import crcs_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire mdu_cmd_type cmd,
   output logic             done,
   output logic [31:0]      result
);
   logic        busy_ff, busy_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        div_ff, div_in;
   logic [31:0] acc_ff, acc_in, a_ff, a_in, b_ff, b_in;
   logic [32:0] trial;

   always_comb begin
      busy_in = busy_ff; cnt_in = cnt_ff; div_in = div_ff;
      acc_in = acc_ff; a_in = a_ff; b_in = b_ff;
      done = busy_ff && (cnt_ff == 6'd32);
      trial = {acc_ff, a_ff[31]} - {1'b0, b_ff};
      if (cmd.start) begin
         busy_in = 1'b1; cnt_in = 6'd0; div_in = cmd.is_div;
         acc_in = '0; a_in = cmd.a; b_in = cmd.b;
      end else if (done) begin
         busy_in = 1'b0; cnt_in = 6'd0;
      end else if (busy_ff) begin
         if (div_ff) begin
            // Restoring division: quotient bits shift into a_ff.
            if (!trial[32]) begin
               acc_in = trial[31:0]; a_in = {a_ff[30:0], 1'b1};
            end else begin
               acc_in = {acc_ff[30:0], a_ff[31]}; a_in = {a_ff[30:0], 1'b0};
            end
         end else begin
            // Shift-add multiply, low 32 bits kept.
            acc_in = (acc_ff << 1) + (a_ff[31] ? b_ff : 32'd0);
            a_in = {a_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
      end
      result = div_ff ? a_ff : acc_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff <= cnt_in;
      end
      div_ff <= div_in; acc_ff <= acc_in; a_ff <= a_in; b_ff <= b_in;
   end
endmodule
`default_nettype wire

// File: rtl/custom_risc_core_step_top.sv
// Top level of the multicycle step core: sequencer, register file and memory.
//
// Channel | Direction | Handshake              | Payload
// req     | in        | req_valid / req_ready  | req_type
// rsp     | out       | rsp_valid / rsp_ready  | rsp_type
//
// A load, start or idle-mode transaction passes from one acceptance to the next
// through apply, result register, hand-off and idle. An executed instruction
// passes through fetch, read wait, decode and register read, execute, write
// back, result register, hand-off and idle; a word or byte load adds a memory
// read state, a fault found in execute skips write back, and a pc range fault
// takes the path of a load. Multiply, divide and multiply-add also wait in the
// bit-serial unit. The word memory and registers are cleared after reset by a
// pass of one word a cycle, during which no transaction is accepted.
// The result sits in an output register; a stalled rsp holds the core.
`timescale 1ns / 1ps
`default_nettype none
module custom_risc_core_step_top import crcs_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);
   localparam logic [3:0] ST_CLR = 4'd0, ST_IDLE = 4'd1, ST_FETCH = 4'd2,
      ST_DEC = 4'd3, ST_EXE = 4'd4, ST_MDU = 4'd5, ST_MEM = 4'd6,
      ST_WB = 4'd7, ST_OUT = 4'd8, ST_RSP = 4'd9, ST_RD = 4'd10;

   logic [3:0]  state_ff, state_in;
   req_type     req_ff;
   logic [31:0] pc_ff, pc_in;
   logic        run_ff, run_in;
   logic [2:0]  err_ff, err_in;
   logic [31:0] word_ff, word_in;
   logic [31:0] a_ff, b_ff, d_ff, res_ff, res_in;
   logic [4:0]  wreg_ff, wreg_in;
   logic        wen_ff, wen_in;
   logic [MemAw:0] clr_ff;
   rsp_type     rsp_ff;
   logic        rsp_valid_ff;

   // Register file and word memory.
   logic [31:0] regs [32];
   logic [31:0] mem [MemWords];
   logic [31:0] mem_rd_ff;
   logic [MemAw-1:0] mem_addr;
   logic        mem_we;
   logic [31:0] mem_wd;

   // Decoded fields.
   logic [5:0]  op;
   logic [4:0]  rd, rs, rt;
   logic [31:0] imm, ea, xa;
   logic        addr_ok;
   assign op  = word_ff[31:26];
   assign rd  = word_ff[25:21];
   assign rs  = word_ff[20:16];
   assign rt  = word_ff[15:11];
   assign imm = {{16{word_ff[15]}}, word_ff[15:0]};
   assign ea  = a_ff + imm;
   assign xa  = (ea >= DataBase) ? ea - DataBase + DataShift : ea;
   assign addr_ok = xa < MemBytes;

   mdu_cmd_type mcmd;
   logic        mdone;
   logic [31:0] mres;
   crcs_mdu u_mdu (.clock(clock), .reset(reset), .cmd(mcmd), .done(mdone), .result(mres));

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      state_in = state_ff; pc_in = pc_ff; run_in = run_ff; err_in = err_ff;
      word_in = word_ff; res_in = res_ff; wreg_in = wreg_ff; wen_in = 1'b0;
      mem_we = 1'b0; mem_wd = req_ff.load_data;
      mem_addr = pc_ff[MemAw+1:2];
      mcmd = '{start: 1'b0, is_div: 1'b0, a: a_ff, b: b_ff};
      unique case (state_ff)
         ST_CLR: begin
            mem_we = 1'b1; mem_wd = '0; mem_addr = clr_ff[MemAw-1:0];
            if (clr_ff[MemAw]) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            err_in = ERR_NONE; word_in = '0;
            if (req_valid) state_in = ST_FETCH;
         end
         ST_FETCH: begin
            state_in = ST_OUT;
            if (req_ff.mode == MODE_LOAD) begin
               mem_addr = req_ff.word_index[MemAw-1:0];
               mem_we = 1'b1;
            end else if (req_ff.mode == MODE_START) begin
               pc_in = '0; run_in = 1'b1;
            end else if (req_ff.mode == MODE_EXEC && run_ff) begin
               if (pc_ff[31:2] >= 30'(MemWords)) begin
                  err_in = ERR_PC; run_in = 1'b0;
               end else begin
                  state_in = ST_RD;
               end
            end
         end
         ST_RD:  state_in = ST_DEC;   // memory read data registered
         ST_DEC: begin
            word_in = mem_rd_ff; state_in = ST_EXE;   // operands read next edge
         end
         ST_EXE: begin
            state_in = ST_WB; wreg_in = rd; wen_in = 1'b1;
            pc_in = pc_ff + 32'd4;
            priority case (1'b1)
               op[5]: begin
                  err_in = ERR_OP; run_in = 1'b0; wen_in = 1'b0; pc_in = pc_ff;
               end
               default: begin
                  unique case (op)
                     OP_ADD:  res_in = a_ff + b_ff;
                     OP_SUB:  res_in = a_ff - b_ff;
                     OP_NOT:  res_in = ~a_ff;
                     OP_AND:  res_in = a_ff & b_ff;
                     OP_NAND: res_in = ~(a_ff & b_ff);
                     OP_OR:   res_in = a_ff | b_ff;
                     OP_XOR:  res_in = a_ff ^ b_ff;
                     OP_XNOR: res_in = ~(a_ff ^ b_ff);
                     OP_MOV:  res_in = a_ff;
                     OP_SGT:  res_in = {31'd0, a_ff > b_ff};
                     OP_SLT:  res_in = {31'd0, a_ff < b_ff};
                     OP_ADDI: res_in = a_ff + imm;
                     OP_SUBI: res_in = a_ff - imm;
                     OP_ANDI: res_in = a_ff & imm;
                     OP_NANDI: res_in = ~(a_ff & imm);
                     OP_ORI:  res_in = a_ff | imm;
                     OP_XORI: res_in = a_ff ^ imm;
                     OP_CLR:  res_in = '0;
                     OP_MUL, OP_MAD, OP_MULI, OP_DIV, OP_DIVI: begin
                        wen_in = 1'b0; pc_in = pc_ff;
                        if ((op == OP_DIV && b_ff == '0) || (op == OP_DIVI && imm == '0)) begin
                           err_in = ERR_DIV0; run_in = 1'b0;
                        end else begin
                           mcmd.start = 1'b1;
                           mcmd.is_div = (op == OP_DIV || op == OP_DIVI);
                           mcmd.b = (op == OP_MULI || op == OP_DIVI) ? imm : b_ff;
                           state_in = ST_MDU;
                        end
                     end
                     OP_LW, OP_LB, OP_SW, OP_SB: begin
                        wen_in = 1'b0; pc_in = pc_ff;
                        if (!addr_ok) begin
                           err_in = ERR_ADDR; run_in = 1'b0;
                        end else begin
                           mem_addr = xa[MemAw+1:2];
                           if (op == OP_SW || op == OP_SB) begin
                              mem_we = 1'b1;
                              mem_wd = (op == OP_SB) ? {24'd0, d_ff[7:0]} : d_ff;
                              pc_in = pc_ff + 32'd4; wen_in = 1'b1; wreg_in = 5'd0;
                              res_in = '0;
                           end else begin
                              state_in = ST_MEM;
                           end
                        end
                     end
                     OP_BEQ: begin
                        wen_in = 1'b0;
                        if (d_ff == a_ff) pc_in = pc_ff + ((imm - 32'd4) << 2) + 32'd4;
                     end
                     OP_BNE: begin
                        wen_in = 1'b0;
                        if (d_ff != a_ff) pc_in = pc_ff + (imm << 2) + 32'd4;
                     end
                     OP_JMP: begin
                        wen_in = 1'b0; pc_in = {4'd0, word_ff[25:0], 2'b00} - 32'd4;
                     end
                     OP_JAL: begin
                        wreg_in = 5'd31; res_in = pc_ff + 32'd4;
                        pc_in = {4'd0, word_ff[25:0], 2'b00};
                     end
                     OP_HALT: begin
                        wen_in = 1'b0; run_in = 1'b0;
                     end
                     default: wen_in = 1'b0;
                  endcase
               end
            endcase
            if (err_in != ERR_NONE) state_in = ST_OUT;
         end
         ST_MDU: begin
            if (mdone) begin
               res_in = (op == OP_MAD) ? mres + d_ff : mres;
               wreg_in = rd; wen_in = 1'b1; pc_in = pc_ff + 32'd4; state_in = ST_WB;
            end
         end
         ST_MEM: begin
            mem_addr = xa[MemAw+1:2];
            state_in = ST_WB; wen_in = 1'b1; wreg_in = rd; pc_in = pc_ff + 32'd4;
         end
         ST_WB: state_in = ST_OUT;   // r0 forced to zero here
         ST_OUT: state_in = ST_RSP;
         ST_RSP: if (!rsp_valid_ff || rsp_ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // The load address is presented in execute and again in ST_MEM, so the
   // loaded word sits in mem_rd_ff during write back.
   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_addr] <= mem_wd;
      mem_rd_ff <= mem[mem_addr];
      if (state_ff == ST_WB) begin
         if (wen_ff && wreg_ff != 5'd0) begin
            if (op == OP_LW) regs[wreg_ff] <= mem_rd_ff;
            else if (op == OP_LB) regs[wreg_ff] <= {24'd0, mem_rd_ff[7:0]};
            else regs[wreg_ff] <= res_ff;
         end
         regs[0] <= '0;
      end
      if (state_ff == ST_CLR && clr_ff[MemAw:5] == '0)
         regs[clr_ff[4:0]] <= '0;
      if (state_ff == ST_DEC) begin
         a_ff <= regs[mem_rd_ff[20:16]];
         b_ff <= regs[mem_rd_ff[15:11]];
         d_ff <= regs[mem_rd_ff[25:21]];
      end
      if (req_valid && req_ready) req_ff <= req_data;
      res_ff <= res_in; wreg_ff <= wreg_in; word_ff <= word_in;
      err_ff <= err_in;
      if (state_ff == ST_OUT) begin
         rsp_ff.pc_value <= pc_ff; rsp_ff.running <= run_ff;
         rsp_ff.error_code <= err_ff; rsp_ff.reg_value <= regs[req_ff.reg_select];
         rsp_ff.executed_word <= (err_ff == ERR_PC) ? 32'd0 : word_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLR; pc_ff <= '0; run_ff <= 1'b0; clr_ff <= '0;
         wen_ff <= 1'b0; rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in; pc_ff <= pc_in; run_ff <= run_in;
         wen_ff <= (state_ff == ST_WB) ? 1'b0 : (wen_in | wen_ff & state_ff == ST_MDU);
         if (state_ff == ST_CLR) clr_ff <= clr_ff + (MemAw+1)'(1);
         if (state_ff == ST_OUT) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end
endmodule
`default_nettype wire

// File: rtl/crcs_checker.sv
// Port-level checker for the step core, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module crcs_checker import crcs_pkg::*; (
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_ready,
   input wire logic    rsp_valid,
   input wire logic    rsp_ready,
   input wire rsp_type rsp_data
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("accepted two transactions back to back");
   a_err_stops: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.error_code != ERR_NONE |-> !rsp_data.running)
      else $error("error reported while running");
   a_pc_no_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.error_code == ERR_PC |-> rsp_data.executed_word == '0)
      else $error("word reported without fetch");
endmodule
bind custom_risc_core_step_top crcs_checker u_chk (.*);
`default_nettype wire

// File: bench/core_step_checker.sv
// Checker that predicts the step core's result for each request and compares it.
`timescale 1ns / 1ps
`default_nettype none
module core_step_checker import crcs_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   input  wire logic    req_ready,
   input  wire req_type req_data,
   input  wire logic    rsp_valid,
   input  wire logic    rsp_ready,
   input  wire rsp_type rsp_data,
   output int           fail_count,
   output int           pending_count,
   output int           exec_count
);
   logic [31:0] gpr [32];
   logic [31:0] pc_model;
   logic        run_model;
   logic [31:0] mem_model [MemWords];
   rsp_type     expected_rsp_q [$];

   // Data addresses at or above the data base fold into the upper half of memory.
   function automatic logic map_data_addr(input logic [31:0] a, output logic [31:0] wi);
      logic [31:0] t;
      t = a;
      if (t >= DataBase) t = t - DataBase + DataShift;
      wi = t >> 2;
      return t < MemBytes;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t mismatch %s: got %h want %h", $time, what, got, want);
      fail_count++;
   endtask

   function automatic logic [2:0] run_instr(input logic [31:0] w);
      logic [5:0]  op;
      logic [4:0]  rd, rs, rt;
      logic [31:0] imm, a, b, wi;
      op = w[31:26]; rd = w[25:21]; rs = w[20:16]; rt = w[15:11];
      imm = {{16{w[15]}}, w[15:0]};
      a = gpr[rs]; b = gpr[rt];
      case (op)
         OP_ADD: gpr[rd] = a + b;
         OP_SUB: gpr[rd] = a - b;
         OP_MUL: gpr[rd] = a * b;
         OP_DIV: begin
            if (b == 0) return ERR_DIV0;
            gpr[rd] = a / b;
         end
         OP_NOT: gpr[rd] = ~a;
         OP_AND: gpr[rd] = a & b;
         OP_NAND: gpr[rd] = ~(a & b);
         OP_OR: gpr[rd] = a | b;
         OP_XOR: gpr[rd] = a ^ b;
         OP_XNOR: gpr[rd] = ~(a ^ b);
         OP_MOV: gpr[rd] = a;
         OP_SGT: gpr[rd] = (a > b) ? 32'd1 : 32'd0;
         OP_SLT: gpr[rd] = (a < b) ? 32'd1 : 32'd0;
         OP_MAD: gpr[rd] = a * b + gpr[rd];
         OP_ADDI: gpr[rd] = a + imm;
         OP_SUBI: gpr[rd] = a - imm;
         OP_MULI: gpr[rd] = a * imm;
         OP_DIVI: begin
            if (imm == 0) return ERR_DIV0;
            gpr[rd] = a / imm;
         end
         OP_ANDI: gpr[rd] = a & imm;
         OP_NANDI: gpr[rd] = ~(a & imm);
         OP_ORI: gpr[rd] = a | imm;
         OP_XORI: gpr[rd] = a ^ imm;
         OP_LW, OP_SW, OP_LB, OP_SB: begin
            if (!map_data_addr(a + imm, wi)) return ERR_ADDR;
            if (op == OP_LW) gpr[rd] = mem_model[wi];
            else if (op == OP_SW) mem_model[wi] = gpr[rd];
            else if (op == OP_LB) gpr[rd] = mem_model[wi] & 32'hFF;
            else mem_model[wi] = gpr[rd] & 32'hFF;
         end
         OP_BEQ: if (gpr[rd] == a) pc_model += (imm - 32'd4) * 32'd4;
         OP_BNE: if (gpr[rd] != a) pc_model += imm * 32'd4;
         OP_CLR: gpr[rd] = 32'd0;
         OP_JMP: pc_model = {6'd0, w[25:0]} * 32'd4 - 32'd8;
         OP_JAL: begin
            gpr[31] = pc_model + 32'd4;
            pc_model = {6'd0, w[25:0]} * 32'd4 - 32'd4;
         end
         OP_HALT: run_model = 1'b0;
         default: return ERR_OP;
      endcase
      return ERR_NONE;
   endfunction

   function automatic rsp_type step_core(input req_type r);
      rsp_type o;
      o = '0;
      if (r.mode == MODE_LOAD) begin
         mem_model[r.word_index] = r.load_data;
      end else if (r.mode == MODE_START) begin
         pc_model = 0;
         run_model = 1'b1;
      end else if (r.mode == MODE_EXEC && run_model) begin
         if ((pc_model >> 2) >= MemWords) begin
            o.error_code = ERR_PC;
            run_model = 1'b0;
         end else begin
            o.executed_word = mem_model[pc_model >> 2];
            o.error_code = run_instr(o.executed_word);
            if (o.error_code != ERR_NONE) begin
               run_model = 1'b0;
            end else begin
               pc_model += 4;
               gpr[0] = 0;
            end
         end
      end
      o.pc_value = pc_model;
      o.running = run_model;
      o.reg_value = gpr[r.reg_select];
      return o;
   endfunction

   // The prediction updates blocking state; this block is the only writer.
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         for (int i = 0; i < 32; i++) gpr[i] = '0;
         for (int i = 0; i < MemWords; i++) mem_model[i] = '0;
         pc_model = '0;
         run_model = 1'b0;
         fail_count = 0;
         exec_count = 0;
         expected_rsp_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp_q.size() == 0) begin
               report_mismatch("unexpected transaction", rsp_data.pc_value, 0);
            end else begin
               want = expected_rsp_q.pop_front();
               if (rsp_data.pc_value !== want.pc_value)
                  report_mismatch("pc_value", rsp_data.pc_value, want.pc_value);
               if (rsp_data.running !== want.running)
                  report_mismatch("running", rsp_data.running, want.running);
               if (rsp_data.error_code !== want.error_code)
                  report_mismatch("error_code", rsp_data.error_code, want.error_code);
               if (rsp_data.reg_value !== want.reg_value)
                  report_mismatch("reg_value", rsp_data.reg_value, want.reg_value);
               if (rsp_data.executed_word !== want.executed_word)
                  report_mismatch("executed_word", rsp_data.executed_word,
                                  want.executed_word);
            end
         end
         if (req_valid && req_ready) begin
            want = step_core(req_data);
            if (want.executed_word != 0 || want.error_code != ERR_NONE) exec_count++;
            expected_rsp_q.push_back(want);
         end
      end
      pending_count = expected_rsp_q.size();
   end
endmodule
`default_nettype wire

// File: bench/tb_custom_risc_core_step_top.sv
// Testbench top: makes program stimulus and idling, and gives the verdict.
`timescale 1ns / 1ps
`default_nettype none
module tb_custom_risc_core_step_top;
   import crcs_pkg::*;

   localparam int IdleLimit = 60000;  // covers the memory clearing pass after reset

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;
   int      fail_count, pending_count, exec_count;
   int      idle_cycles;
   int      sent_count = 0;
   int      burst_left = 0;

   always #2 clock = ~clock;

   custom_risc_core_step_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   core_step_checker checker_i (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .fail_count(fail_count), .pending_count(pending_count), .exec_count(exec_count)
   );

   // The receiver stalls on its own pattern: long open stretches alternate
   // with phases of random back-pressure.
   always_ff @(posedge clock) begin
      int phase;
      phase = int'(($time / 4000) % 3);
      if (phase == 0) rsp_ready <= 1'b1;
      else if (phase == 1) rsp_ready <= ($urandom_range(0, 3) != 0);
      else rsp_ready <= ($urandom_range(0, 1) != 0);
   end

   // The watchdog ends the run when no transaction moves for too long.
   always_ff @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
         $display("timeout with %0d results outstanding", pending_count);
         $display("[custom_risc_core_step_top] ERROR");
         $finish;
      end
   end

   function automatic logic [31:0] rtype(input logic [5:0] op, input logic [4:0] rd,
                                         input logic [4:0] rs, input logic [4:0] rt);
      return {op, rd, rs, rt, 11'd0};
   endfunction

   function automatic logic [31:0] itype(input logic [5:0] op, input logic [4:0] rd,
                                         input logic [4:0] rs, input logic [15:0] imm);
      return {op, rd, rs, imm};
   endfunction

   // Random instruction, mostly well-formed: ops 0..31 with small register
   // numbers so that values flow between instructions, rarely a bad opcode.
   function automatic logic [31:0] random_instr();
      logic [5:0]  op;
      logic [15:0] imm;
      int          pick;
      pick = $urandom_range(0, 99);
      op = (pick < 3) ? 6'($urandom_range(32, 63)) : 6'($urandom_range(0, 31));
      imm = 16'($urandom);
      if (op == OP_JMP || op == OP_JAL) begin
         // Jump targets stay mostly inside the small program area.
         if ($urandom_range(0, 9) != 0) return {op, 26'($urandom_range(2, 40))};
         return {op, 26'($urandom)};
      end
      if (op == OP_BEQ || op == OP_BNE) imm = 16'($urandom_range(0, 10));
      if (op >= OP_LW && op <= OP_SB) begin
         case ($urandom_range(0, 3))
            0: imm = 16'($urandom_range(0, 255) * 4);
            1: imm = 16'h8000 | 16'($urandom);
            default: imm = 16'($urandom_range(0, 127));
         endcase
      end
      if (op == OP_HALT && $urandom_range(0, 2) != 0) op = OP_ADDI;
      return {op, 5'($urandom_range(0, 7)), 5'($urandom_range(0, 7)),
              (pick < 50) ? imm : {5'($urandom_range(0, 7)), imm[10:0]}};
   endfunction

   // Sends one transaction; the sender works in bursts with random gaps.
   task automatic send(input logic [1:0] mode, input logic [13:0] idx,
                       input logic [31:0] data, input logic [4:0] sel);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = $urandom_range(0, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data <= '{mode: mode, word_index: idx, load_data: data, reg_select: sel};
      do @(posedge clock); while (!req_ready);
      sent_count++;
   endtask

   // Stops sending and waits until every expected result has come back.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      wait (pending_count == 0);
      @(posedge clock);
   endtask

   task automatic load_word(input logic [13:0] idx, input logic [31:0] data);
      send(MODE_LOAD, idx, data, 5'($urandom));
   endtask

   task automatic exec_one();
      send(MODE_EXEC, 14'($urandom), 32'($urandom), 5'($urandom));
   endtask

   initial begin
      logic [31:0] prog [$];
      int          n;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed program: field extremes, signed immediates, a load into r0,
      // memory access, and a divide by zero.
      prog = {itype(OP_ADDI, 1, 0, 16'hFFFF), itype(OP_ADDI, 2, 0, 16'h7FFF),
              rtype(OP_MAD, 3, 1, 2), rtype(OP_SGT, 4, 1, 2), rtype(OP_SLT, 5, 1, 2),
              itype(OP_DIVI, 6, 1, 16'h8000), itype(OP_LW, 0, 0, 16'h0000),
              itype(OP_SW, 1, 0, 16'h0100), itype(OP_LB, 7, 0, 16'h0100),
              rtype(OP_DIV, 8, 1, 0), 32'h0};
      for (int i = 0; i < prog.size(); i++) load_word(14'(i), prog[i]);
      load_word(14'h3FFF, 32'hFFFF_FFFF);
      send(MODE_START, 14'h3FFF, 32'hFFFF_FFFF, 5'd31);
      for (int i = 0; i < 9; i++) send(MODE_EXEC, 14'h0, 32'h0, 5'(i));
      send(MODE_EXEC, 14'h0, 32'h0, 5'd8);   // divide by zero stops the run
      send(MODE_UNUSED, 14'h0, 32'h0, 5'd1);
      // Jump far beyond memory to raise the pc range error.
      load_word(14'd0, {OP_JMP, 26'h3FF_FFFF});
      send(MODE_START, 14'd0, 32'd0, 5'd0);
      send(MODE_EXEC, 14'd0, 32'd0, 5'd31);
      send(MODE_EXEC, 14'd0, 32'd0, 5'd31);

      // Random programs: load a short program, start it and step through it.
      // Noise items (stray loads, unused modes) are mixed in.
      while (sent_count < 950) begin
         n = $urandom_range(4, 40);
         for (int i = 0; i < n; i++) load_word(14'(i), random_instr());
         if ($urandom_range(0, 4) == 0)
            load_word(14'($urandom_range(8192, 16383)), 32'($urandom));
         send(MODE_START, 14'($urandom), 32'($urandom), 5'($urandom));
         for (int i = 0; i < n + 10; i++) begin
            case ($urandom_range(0, 39))
               0: send(MODE_UNUSED, 14'($urandom), 32'($urandom), 5'($urandom));
               1: load_word(14'($urandom_range(0, 63)), random_instr());
               default: exec_one();
            endcase
         end
         // Once in a while the sender waits for every result to drain.
         if ($urandom_range(0, 5) == 0) drain();
      end

      drain();
      repeat (50) @(posedge clock);
      $display("Sent %0d transactions; %0d instruction fetches or faults predicted.",
               sent_count, exec_count);
      if (fail_count == 0) $display("[custom_risc_core_step_top] OK");
      else $display("[custom_risc_core_step_top] ERROR");
      $finish;
   end
endmodule
`default_nettype wire
